### rtl/core/dc2cd_pkg.sv
`default_nettype none

package dc2cd_pkg;

	// Payload widths of the two channels.
	localparam int unsigned DAY_COUNT_W = 16;
	localparam int unsigned DAY_W       = 5;
	localparam int unsigned MONTH_W     = 4;
	localparam int unsigned YEAR_W      = 12;

	// Width of a year or month length.
	localparam int unsigned LEN_W = 9;

	// Epoch and its residues modulo 100 and 400.
	localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 12'd1978;
	localparam logic [6:0]        EPOCH_MOD100  = 7'd78;
	localparam logic [8:0]        EPOCH_MOD400  = 9'd378;
	localparam logic [6:0]        LAST_MOD100   = 7'd99;
	localparam logic [8:0]        LAST_MOD400   = 9'd399;

	localparam logic [LEN_W-1:0] YEAR_LEN      = 9'd365;
	localparam logic [LEN_W-1:0] LEAP_YEAR_LEN = 9'd366;

	// Month numbers that the month-length rule and the walker use.
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} dc2cd_state_t;

	// Result of one pass through the shared compare and subtract unit.
	typedef struct packed {
		logic                   go;
		logic [DAY_COUNT_W-1:0] diff;
	} dc2cd_step_t;

	// Days in a month for a common or a leap year.
	function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [LEN_W-1:0] len;
		begin
			case (month) inside
				MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 9'd30;
				MONTH_FEB: len = leap ? 9'd29 : 9'd28;
				default: len = 9'd31;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/dc2cd_days_if.sv
`default_nettype none

// Channel that carries one day count per beat.
interface dc2cd_days_if import dc2cd_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [DAY_COUNT_W-1:0] day_count;

	modport source (output valid, output day_count, input ready);
	modport sink (input valid, input day_count, output ready);
endinterface

`default_nettype wire

### rtl/core/dc2cd_date_if.sv
`default_nettype none

// Channel that carries one calendar date per beat.
interface dc2cd_date_if import dc2cd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [DAY_W-1:0]   day_of_month;
	logic [MONTH_W-1:0] month_number;
	logic [YEAR_W-1:0]  year_number;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, input ready);
	modport sink (input valid, input day_of_month, input month_number,
		input year_number, output ready);
endinterface

`default_nettype wire

### rtl/core/dc2cd_step_unit.sv
`default_nettype none

// Shared compare and subtract: the remainder steps past a year or a month
// only when it is strictly greater than that period's length.
module dc2cd_step_unit import dc2cd_pkg::*; (
	input  wire logic [DAY_COUNT_W-1:0] rem,
	input  wire logic [LEN_W-1:0]       len,
	output dc2cd_step_t                 res
);

	logic [DAY_COUNT_W-1:0] len_ext;

	assign len_ext  = {{(DAY_COUNT_W-LEN_W){1'b0}}, len};
	assign res.go   = rem > len_ext;
	assign res.diff = rem - len_ext;

endmodule

`default_nettype wire

### rtl/core/day_count_to_calendar_date.sv
// Day count to calendar date converter.
//
// A beat on the days channel carries a 16-bit unsigned day count, where
// day 1 is 1 January 1978. A beat on the date channel returns day of month,
// month and full Gregorian year; a count of zero gives day 0 of January 1978.
// Every input beat gives exactly one output beat, in order.
//
// One shared compare and subtract unit walks the count, one step a cycle:
// first whole years, then whole months up to December; the walker then
// passes through its done state, which loads the result register. The days
// channel is ready again in the same cycle that the result turns valid. The
// days channel is ready only while the walker is idle.
//
// The result sits in an output register. While the receiver stalls, a new
// count is still accepted and walked; the finished date then waits in the
// walker until the output register is freed.
//
// The asynchronous reset clears the walker to idle and empties the output.
`default_nettype none

module day_count_to_calendar_date import dc2cd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dc2cd_days_if.sink         days,
	dc2cd_date_if.source       date
);

	dc2cd_state_t state_q, state_d;

	logic [DAY_COUNT_W-1:0] rem_q, rem_d;
	logic [YEAR_W-1:0]      year_q, year_d;
	logic [MONTH_W-1:0]     month_q, month_d;
	logic [6:0]             mod100_q, mod100_d;
	logic [8:0]             mod400_q, mod400_d;

	logic               out_valid_q, out_valid_d;
	logic [DAY_W-1:0]   out_day_q, out_day_d;
	logic [MONTH_W-1:0] out_month_q, out_month_d;
	logic [YEAR_W-1:0]  out_year_q, out_year_d;

	logic             leap;
	logic [LEN_W-1:0] len;
	dc2cd_step_t      step;

	// Gregorian leap rule from the tracked residues.
	assign leap = ((year_q[1:0] == 2'b00) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

	// Length of the period the walker tries to pass.
	assign len = (state_q == ST_YEAR) ? (leap ? LEAP_YEAR_LEN : YEAR_LEN)
		: month_len(month_q, leap);

	dc2cd_step_unit u_step (
		.rem (rem_q),
		.len (len),
		.res (step)
	);

	// Next state and datapath updates of the walker and the output register.
	always_comb begin
		state_d     = state_q;
		rem_d       = rem_q;
		year_d      = year_q;
		month_d     = month_q;
		mod100_d    = mod100_q;
		mod400_d    = mod400_q;
		out_valid_d = out_valid_q;
		out_day_d   = out_day_q;
		out_month_d = out_month_q;
		out_year_d  = out_year_q;
		days.ready  = 1'b0;

		if (out_valid_q && date.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				days.ready = 1'b1;
				if (days.valid) begin
					rem_d    = days.day_count;
					year_d   = EPOCH_YEAR;
					month_d  = MONTH_JAN;
					mod100_d = EPOCH_MOD100;
					mod400_d = EPOCH_MOD400;
					state_d  = ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (step.go) begin
					rem_d    = step.diff;
					year_d   = year_q + 12'd1;
					mod100_d = (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
					mod400_d = (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
				end else begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (step.go && (month_q != MONTH_DEC)) begin
					rem_d   = step.diff;
					month_d = month_q + 4'd1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || date.ready) begin
					out_valid_d = 1'b1;
					out_day_d   = rem_q[DAY_W-1:0];
					out_month_d = month_q;
					out_year_d  = year_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rem_q       <= rem_d;
		year_q      <= year_d;
		month_q     <= month_d;
		mod100_q    <= mod100_d;
		mod400_q    <= mod400_d;
		out_day_q   <= out_day_d;
		out_month_q <= out_month_d;
		out_year_q  <= out_year_d;
	end

	assign date.valid        = out_valid_q;
	assign date.day_of_month = out_day_q;
	assign date.month_number = out_month_q;
	assign date.year_number  = out_year_q;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import dc2cd_pkg::*;

	// One calendar date as the date channel carries it.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} calendar_date_t;

	// Predicts the date for each accepted day count and checks results in order.
	class date_tracker;
		calendar_date_t pending_dates[$];
		int unsigned    errors;

		function new();
			errors = 0;
		endfunction

		// Full Gregorian rule: every fourth year, except centuries not divisible by 400.
		function bit is_leap(int unsigned year);
			return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
		endfunction

		function int unsigned days_in_month(logic [MONTH_W-1:0] month, int unsigned year);
			if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
					month == MONTH_NOV)
				return 30;
			if (month == MONTH_FEB)
				return is_leap(year) ? 29 : 28;
			return 31;
		endfunction

		// Walks whole years, then whole months, off the day count.
		function calendar_date_t predict_date(logic [DAY_COUNT_W-1:0] count);
			calendar_date_t     date;
			int unsigned        remaining;
			int unsigned        year;
			logic [MONTH_W-1:0] month;
			remaining = count;
			year = EPOCH_YEAR;
			month = MONTH_JAN;
			// A remainder of exactly 366 stays in a leap year as its last day.
			while (remaining > 365 && (remaining != 366 || !is_leap(year))) begin
				remaining -= is_leap(year) ? 366 : 365;
				year++;
			end
			while (month < MONTH_DEC && remaining > days_in_month(month, year)) begin
				remaining -= days_in_month(month, year);
				month++;
			end
			date.day = remaining[DAY_W-1:0];
			date.month = month;
			date.year = year[YEAR_W-1:0];
			return date;
		endfunction

		function void note_count(logic [DAY_COUNT_W-1:0] count);
			pending_dates.push_back(predict_date(count));
		endfunction

		function void check_date(calendar_date_t actual);
			calendar_date_t expected;
			if (pending_dates.size() == 0) begin
				$error("unexpected date beat: day %0d month %0d year %0d",
					actual.day, actual.month, actual.year);
				errors++;
				return;
			end
			expected = pending_dates.pop_front();
			if (actual.day !== expected.day) begin
				$error("day_of_month mismatch: expected %0d, actual %0d",
					expected.day, actual.day);
				errors++;
			end
			if (actual.month !== expected.month) begin
				$error("month_number mismatch: expected %0d, actual %0d",
					expected.month, actual.month);
				errors++;
			end
			if (actual.year !== expected.year) begin
				$error("year_number mismatch: expected %0d, actual %0d",
					expected.year, actual.year);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;

	dc2cd_days_if days_ch();
	dc2cd_date_if date_ch();

	date_tracker tracker = new();

	day_count_to_calendar_date u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.days   (days_ch),
		.date   (date_ch)
	);

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard limit on the run, well above the slowest correct run.
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Draws a random wait, or none during a calm stretch.
	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// Offers one day count and returns at the edge that accepts the beat.
	task automatic send_day_count(input logic [DAY_COUNT_W-1:0] count);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			days_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		days_ch.valid <= 1'b1;
		days_ch.day_count <= count;
		do @(posedge clk); while (!days_ch.ready);
		tracker.note_count(count);
	endtask

	// Receiver with a random stall before each beat.
	task automatic receive_dates();
		int unsigned    stall;
		calendar_date_t actual;
		forever begin
			stall = draw_wait();
			if (stall != 0) begin
				date_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			date_ch.ready <= 1'b1;
			do @(posedge clk); while (!date_ch.valid);
			actual.day = date_ch.day_of_month;
			actual.month = date_ch.month_number;
			actual.year = date_ch.year_number;
			tracker.check_date(actual);
		end
	endtask

	// Day count of 31 December of the year before the given one.
	function automatic int unsigned days_before_year(int unsigned year);
		int unsigned total;
		total = 0;
		for (int unsigned y = EPOCH_YEAR; y < year; y++)
			total += tracker.is_leap(y) ? 366 : 365;
		return total;
	endfunction

	// Random count biased toward the first and last days of a year and February.
	function automatic logic [DAY_COUNT_W-1:0] near_year_edge();
		int unsigned base;
		int unsigned count;
		base = days_before_year($urandom_range(EPOCH_YEAR, 2157));
		case ($urandom_range(0, 3))
			0: count = base + $urandom_range(0, 2);
			1: count = base + $urandom_range(58, 61);
			2: count = base + $urandom_range(364, 367);
			default: count = base + $urandom_range(28, 33);
		endcase
		if (count > 65535)
			count = 65535 - $urandom_range(0, 400);
		return count[DAY_COUNT_W-1:0];
	endfunction

	// Reset, then the receiver.
	initial begin
		arst_n = 1'b0;
		date_ch.ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		receive_dates();
	end

	// Stimulus: corner counts first, then random counts.
	initial begin
		// Zero, the epoch, the last day of common and leap years, 2000 as a leap
		// century, 2100 as a common century, month ends and the largest count.
		logic [DAY_COUNT_W-1:0] corner_counts[$] = '{
			16'd0, 16'd1, 16'd2, 16'd31, 16'd32, 16'd59, 16'd60, 16'd365, 16'd366,
			16'd730, 16'd731, 16'd1095, 16'd1096, 16'd8035, 16'd8036, 16'd8095,
			16'd8096, 16'd8401, 16'd8402, 16'd44619, 16'd44620, 16'd44925,
			16'd43465, 16'd32768, 16'd65535};
		int unsigned kind;
		calm = 1'b0;
		days_ch.valid <= 1'b0;
		days_ch.day_count <= '0;
		@(posedge arst_n);
		@(posedge clk);
		foreach (corner_counts[i])
			send_day_count(corner_counts[i]);

		for (int i = 0; i < 850; i++) begin
			// Switch between idling and calm stretches every 40 beats.
			if (i % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 5)
				send_day_count(DAY_COUNT_W'($urandom_range(0, 65535)));
			else if (kind < 8)
				send_day_count(near_year_edge());
			else
				send_day_count(DAY_COUNT_W'($urandom_range(0, 1500)));
		end
		days_ch.valid <= 1'b0;

		// Drain, then allow time for any stray beat to show up.
		while (tracker.pending_dates.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_dates.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
